@@ src/ebb_pkg.sv @@
// ebb_pkg: shared codes, reset values and controller/datapath command types
// for the edge-normalised box blur block. No dependencies.
`default_nettype none
package ebb_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_BLUR  = 2'd2;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL_SIZE  = 2'd2;
  localparam logic [1:0] CFG_BLUR_PASSES  = 2'd3;

  localparam logic [15:0] Q16_ONE    = 16'hFFFF;
  localparam logic [3:0]  PASS_LIMIT = 4'd8;

  localparam logic [8:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [8:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [3:0] RST_KERNEL_SIZE  = 4'd5;
  localparam logic [3:0] RST_BLUR_PASSES  = 4'd1;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic copy_init;
    logic copy_step;
    logic pix_init;
    logic win_init;
    logic win_step;
    logic div_load;
    logic div_step;
    logic pix_write;
    logic out_read;
    logic out_blur;
  } ebb_cmd_t;

  typedef struct packed {
    logic       in_rd_hit;
    logic       in_blur;
    logic       out_free;
    logic       clr_last;
    logic       copy_last;
    logic       win_last;
    logic       div_last;
    logic       pix_last;
    logic       frame_empty;
    logic [3:0] passes;
  } ebb_sts_t;

endpackage
`default_nettype wire

@@ src/ebb_in_if.sv @@
// ebb_in_if: input item channel (valid/ready plus request fields)
// no dependencies
`default_nettype none
interface ebb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] pixel_value;
  modport source (output valid, action, pixel_x, pixel_y, pixel_value, input ready);
  modport sink   (input valid, action, pixel_x, pixel_y, pixel_value, output ready);
endinterface
`default_nettype wire

@@ src/ebb_out_if.sv @@
// ebb_out_if: result channel (valid/ready plus read value and status)
// no dependencies
`default_nettype none
interface ebb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic        status;
  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface
`default_nettype wire

@@ src/ebb_cfg_if.sv @@
// ebb_cfg_if: configuration write channel (register index and data)
// no dependencies
`default_nettype none
interface ebb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/ebb_datapath.sv @@
// ebb_datapath: config registers, frame and copy memories, window walk,
// accumulator, serial divider and result register. Uses ebb_pkg.
`default_nettype none
module ebb_datapath import ebb_pkg::*; #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int MAX_HALF_KERNEL = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ebb_cmd_t    cmd,
  output ebb_sts_t    sts,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [15:0] in_pixel_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] out_read_value,
  output logic        out_status
);

  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW   = XW + YW;
  localparam int WCW  = XW + 1;
  localparam int HCW  = YW + 1;
  localparam int XE   = ((XW > 4) ? XW : 4) + 1;
  localparam int YE   = ((YW > 4) ? YW : 4) + 1;
  localparam int KW   = 2 * MAX_HALF_KERNEL + 1;
  localparam int CNTW = $clog2(KW * KW + 1);
  localparam int SUMW = 16 + CNTW;
  localparam int DCW  = $clog2(SUMW);

  logic [8:0] fw_r, fh_r;
  logic [3:0] ks_r, bp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= RST_FRAME_WIDTH;
      fh_r <= RST_FRAME_HEIGHT;
      ks_r <= RST_KERNEL_SIZE;
      bp_r <= RST_BLUR_PASSES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_data;
        CFG_FRAME_HEIGHT: fh_r <= cfg_data;
        CFG_KERNEL_SIZE:  ks_r <= cfg_data[3:0];
        CFG_BLUR_PASSES:  bp_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic [XW-1:0]  wl;
  logic [YW-1:0]  hl;
  logic [3:0]     half_raw, half;

  assign w_eff    = (32'(fw_r) > MAX_WIDTH) ? WCW'(MAX_WIDTH) : WCW'(fw_r);
  assign h_eff    = (32'(fh_r) > MAX_HEIGHT) ? HCW'(MAX_HEIGHT) : HCW'(fh_r);
  assign wl       = XW'(w_eff - WCW'(1));
  assign hl       = YW'(h_eff - HCW'(1));
  assign half_raw = ks_r >> 1;
  assign half     = (32'(half_raw) > MAX_HALF_KERNEL) ? 4'(MAX_HALF_KERNEL) : half_raw;

  logic          in_frame;
  logic [AW-1:0] in_addr;
  assign in_frame = (32'(in_pixel_x) < 32'(w_eff)) && (32'(in_pixel_y) < 32'(h_eff));
  assign in_addr  = {YW'(in_pixel_y), XW'(in_pixel_x)};

  // counters: clear sweep, copy sweep, output pixel, window position
  logic [AW-1:0]   clr_r;
  logic [XW-1:0]   cx_r, px_r, wx_r, x0_r, x1_r;
  logic [YW-1:0]   cy_r, py_r, wy_r, y1_r;
  logic [CNTW-1:0] cnt_r;
  logic [SUMW-1:0] acc_r, quo_r;
  logic [CNTW-1:0] rem_r;
  logic [DCW-1:0]  dcnt_r;
  logic            acc_pend_r, cpy_pend_r;
  logic [AW-1:0]   cpy_wa_r;
  logic [15:0]     occ_rd_r, copy_rd_r;

  // window bounds clipped to the frame
  logic [XE-1:0] xs;
  logic [YE-1:0] ys;
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  assign xs = XE'(px_r) + XE'(half);
  assign ys = YE'(py_r) + YE'(half);
  assign x0 = (XE'(px_r) > XE'(half)) ? XW'(XE'(px_r) - XE'(half)) : '0;
  assign y0 = (YE'(py_r) > YE'(half)) ? YW'(YE'(py_r) - YE'(half)) : '0;
  assign x1 = (xs > XE'(wl)) ? wl : XW'(xs);
  assign y1 = (ys > YE'(hl)) ? hl : YW'(ys);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      acc_pend_r <= 1'b0;
      cpy_pend_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      acc_pend_r <= cmd.win_step;
      cpy_pend_r <= cmd.copy_step;
    end
  end

  // divider step: shift one dividend bit into the remainder
  logic [CNTW:0] trial;
  logic          ge;
  assign trial = {rem_r, quo_r[SUMW-1]};
  assign ge    = trial >= {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.copy_init) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cmd.copy_step) begin
      if (cx_r == wl) begin
        cx_r <= '0;
        cy_r <= cy_r + YW'(1);
      end else begin
        cx_r <= cx_r + XW'(1);
      end
    end
    cpy_wa_r <= {cy_r, cx_r};

    if (cmd.pix_init) begin
      px_r <= '0;
      py_r <= '0;
    end else if (cmd.pix_write) begin
      if (px_r == wl) begin
        px_r <= '0;
        py_r <= py_r + YW'(1);
      end else begin
        px_r <= px_r + XW'(1);
      end
    end

    if (cmd.win_init) begin
      wx_r  <= x0;
      wy_r  <= y0;
      x0_r  <= x0;
      x1_r  <= x1;
      y1_r  <= y1;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.win_step) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (wx_r == x1_r) begin
          wx_r <= x0_r;
          wy_r <= wy_r + YW'(1);
        end else begin
          wx_r <= wx_r + XW'(1);
        end
      end
      if (acc_pend_r) acc_r <= acc_r + SUMW'(copy_rd_r);
    end

    if (cmd.div_load) begin
      quo_r  <= acc_r;
      rem_r  <= '0;
      dcnt_r <= DCW'(SUMW - 1);
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUMW-2:0], ge};
      rem_r  <= ge ? CNTW'(trial - {1'b0, cnt_r}) : CNTW'(trial);
      dcnt_r <= dcnt_r - DCW'(1);
    end
  end

  // frame store and per-pass copy
  logic [15:0]   occ_mem  [2**AW];
  logic [15:0]   copy_mem [2**AW];
  logic          occ_we, occ_re;
  logic [AW-1:0] occ_wa, occ_ra;
  logic [15:0]   occ_wd;

  always_comb begin
    occ_we = 1'b0;
    occ_wa = clr_r;
    occ_wd = Q16_ONE;
    if (cmd.clr_step) begin
      occ_we = 1'b1;
    end else if (cmd.pix_write) begin
      occ_we = 1'b1;
      occ_wa = {py_r, px_r};
      occ_wd = quo_r[15:0];
    end else if (cmd.accept && in_action == ACT_WRITE && in_frame) begin
      occ_we = 1'b1;
      occ_wa = in_addr;
      occ_wd = in_pixel_value;
    end
    occ_re = cmd.accept || cmd.copy_step;
    occ_ra = cmd.copy_step ? {cy_r, cx_r} : in_addr;
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
  end

  always_ff @(posedge clk) begin
    if (occ_re) occ_rd_r <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (cpy_pend_r) copy_mem[cpy_wa_r] <= occ_rd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.win_step) copy_rd_r <= copy_mem[{wy_r, wx_r}];
  end

  // result register
  logic        out_valid_r, out_st_r;
  logic [15:0] out_rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_read || cmd.out_blur) begin
      out_valid_r <= 1'b1;
    end else if (cmd.accept && !(in_action == ACT_READ && in_frame) &&
                 in_action != ACT_BLUR) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_read) begin
      out_rv_r <= occ_rd_r;
      out_st_r <= 1'b0;
    end else if (cmd.out_blur) begin
      out_rv_r <= '0;
      out_st_r <= 1'b0;
    end else if (cmd.accept) begin
      out_rv_r <= (in_action == ACT_READ) ? Q16_ONE : 16'd0;
      out_st_r <= (in_action == ACT_READ || in_action == ACT_WRITE) && !in_frame;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_status     = out_st_r;

  always_comb begin
    sts.in_rd_hit   = (in_action == ACT_READ) && in_frame;
    sts.in_blur     = (in_action == ACT_BLUR);
    sts.out_free    = !out_valid_r || out_ready;
    sts.clr_last    = &clr_r;
    sts.copy_last   = (cx_r == wl) && (cy_r == hl);
    sts.win_last    = (wx_r == x1_r) && (wy_r == y1_r);
    sts.div_last    = (dcnt_r == '0);
    sts.pix_last    = (px_r == wl) && (py_r == hl);
    sts.frame_empty = (w_eff == '0) || (h_eff == '0);
    sts.passes      = (bp_r > PASS_LIMIT) ? PASS_LIMIT : bp_r;
  end

endmodule
`default_nettype wire

@@ src/ebb_ctrl.sv @@
// ebb_ctrl: sequencer for clearing, pixel access and blur passes
// drives ebb_datapath through ebb_cmd_t, uses ebb_pkg
`default_nettype none
module ebb_ctrl import ebb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ebb_sts_t sts,
  output ebb_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_PASS, S_COPY, S_WIN_INIT,
    S_WIN, S_DRAIN, S_DIV_LOAD, S_DIV, S_WRBACK
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] pass_r, pass_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (sts.in_blur) begin
            pass_nxt  = '0;
            state_nxt = S_PASS;
          end else if (sts.in_rd_hit) begin
            state_nxt = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.out_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_PASS: begin
        if (pass_r < sts.passes && !sts.frame_empty) begin
          cmd.copy_init = 1'b1;
          pass_nxt      = pass_r + 4'd1;
          state_nxt     = S_COPY;
        end else begin
          cmd.out_blur = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          cmd.pix_init = 1'b1;
          state_nxt    = S_WIN_INIT;
        end
      end
      S_WIN_INIT: begin
        cmd.win_init = 1'b1;
        state_nxt    = S_WIN;
      end
      S_WIN: begin
        cmd.win_step = 1'b1;
        if (sts.win_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DIV_LOAD;
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_WRBACK;
      end
      S_WRBACK: begin
        cmd.pix_write = 1'b1;
        state_nxt     = sts.pix_last ? S_PASS : S_WIN_INIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r <= PASS_LIMIT) else $error("pass count overrun");
  a_rd_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD_WAIT |-> $past(state_r) == S_IDLE) else $error("bad read entry");
  a_div_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_LOAD |=> state_r == S_DIV) else $error("divider not started");

endmodule
`default_nettype wire

@@ src/edge_normalized_box_blur_top.sv @@
// edge_normalized_box_blur_top: top level joining ebb_ctrl and ebb_datapath
// depends on ebb_pkg and the ebb_in_if, ebb_out_if and ebb_cfg_if interfaces
//
// Occlusion frame store with in-place box blur. After reset a clearing sweep
// writes 1.0 to every entry, one entry a cycle, with no item accepted (config
// writes are taken). A read inside the frame waits in S_RD_WAIT for the
// registered read of the frame memory. A blur item runs, per pass, a decision
// in S_PASS and a copy of the W*H frame, then for every pixel S_WIN_INIT, a
// walk over its clipped window of N pixels (one copy-memory read a cycle),
// S_DRAIN, S_DIV_LOAD, the serial divider's 16+ceil(log2(KW*KW+1)) steps and
// S_WRBACK; a last S_PASS decision ends the item. With the default half-width
// limit of 7 (15x15 window) that is 24 divider steps per pixel. A result that
// is still waiting holds off the next item unless it is taken in that cycle.
`default_nettype none
module edge_normalized_box_blur_top import ebb_pkg::*; #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int MAX_HALF_KERNEL = 7
) (
  input logic        clk,
  input logic        rst_n,
  ebb_in_if.sink     in_chan,
  ebb_out_if.source  out_chan,
  ebb_cfg_if.sink    cfg_chan
);

  ebb_cmd_t cmd;
  ebb_sts_t sts;

  assign cfg_chan.ready = 1'b1;

  ebb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ebb_datapath #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_HALF_KERNEL (MAX_HALF_KERNEL)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_chan.action),
    .in_pixel_x     (in_chan.pixel_x),
    .in_pixel_y     (in_chan.pixel_y),
    .in_pixel_value (in_chan.pixel_value),
    .cfg_we         (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_read_value (out_chan.read_value),
    .out_status     (out_chan.status)
  );

endmodule
`default_nettype wire
